### hdl/eca_pkg.sv
// shared types and constants of the earliest finish counter assigner
package eca_pkg;

  // fixed field widths
  localparam int unsigned SVC_W      = 16;
  localparam int unsigned FIN_W      = 32;
  localparam int unsigned SRV_OUT_W  = 2;
  localparam int unsigned LOAD_OUT_W = 16;
  localparam int unsigned IN_USE_W   = 3;

  // parameter defaults
  localparam int unsigned NUM_SERVERS_DEF = 4;
  localparam int unsigned TALLY_W_DEF     = 16;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // register indexes: service times sit at 0 .. REG_SERVICE_COUNT-1
  localparam int unsigned           REG_SERVICE_COUNT  = 4;
  localparam logic [CFG_IDX_W-1:0]  REG_SERVERS_IN_USE = 3'd4;

  // reset values
  localparam logic [SVC_W-1:0]    SVC_RST    = 16'd1;
  localparam logic [IN_USE_W-1:0] IN_USE_RST = 3'd4;

  // stream widths
  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned OUT_TDATA_W = 88;

  // update command from the pipeline to the server bank
  typedef struct packed {
    logic en;     // a job is assigned this cycle
    logic start;  // the job opens a new batch
  } upd_t;

endpackage

### hdl/eca_argmin.sv
// earliest finish selection over the servers in use
module eca_argmin #(
  parameter int unsigned NUM_SERVERS = eca_pkg::NUM_SERVERS_DEF,
  parameter int unsigned TALLY_WIDTH = eca_pkg::TALLY_W_DEF,
  localparam int unsigned IW = (NUM_SERVERS > 1) ? $clog2(NUM_SERVERS) : 1
) (
  input  logic [NUM_SERVERS-1:0][eca_pkg::FIN_W-1:0] fin_i,
  input  logic [NUM_SERVERS-1:0][eca_pkg::SVC_W-1:0] svc_i,
  input  logic [NUM_SERVERS-1:0][TALLY_WIDTH-1:0]    tally_i,
  input  logic [NUM_SERVERS-1:0]                     mask_i,
  output logic [IW-1:0]                              best_idx_o,
  output logic [eca_pkg::FIN_W-1:0]                  best_fin_o,
  output logic [TALLY_WIDTH-1:0]                     best_tally_o
);

  // scan in index order; strictly smaller finish wins, ties go to the faster server
  always_comb begin
    logic [IW-1:0]             bi;
    logic [eca_pkg::FIN_W-1:0] bf;
    logic [eca_pkg::SVC_W-1:0] bs;
    logic [TALLY_WIDTH-1:0]    bt;
    bi = '0;
    bf = fin_i[0];
    bs = svc_i[0];
    bt = tally_i[0];
    for (int s = 1; s < NUM_SERVERS; s++) begin
      if (mask_i[s] && ((fin_i[s] < bf) || ((fin_i[s] == bf) && (svc_i[s] < bs)))) begin
        bi = IW'(s);
        bf = fin_i[s];
        bs = svc_i[s];
        bt = tally_i[s];
      end
    end
    best_idx_o   = bi;
    best_fin_o   = bf;
    best_tally_o = bt;
  end

endmodule

### hdl/eca_server_bank.sv
// per-server service times, tallies and running finish times
module eca_server_bank #(
  parameter int unsigned NUM_SERVERS = eca_pkg::NUM_SERVERS_DEF,
  parameter int unsigned TALLY_WIDTH = eca_pkg::TALLY_W_DEF,
  localparam int unsigned IW = (NUM_SERVERS > 1) ? $clog2(NUM_SERVERS) : 1
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       cfg_valid_i,
  input  logic [eca_pkg::CFG_IDX_W-1:0]              cfg_index_i,
  input  logic [eca_pkg::CFG_DATA_W-1:0]             cfg_data_i,
  input  eca_pkg::upd_t                              upd_i,
  input  logic [IW-1:0]                              upd_idx_i,
  output logic [NUM_SERVERS-1:0][eca_pkg::FIN_W-1:0] eff_fin_o,
  output logic [NUM_SERVERS-1:0][eca_pkg::SVC_W-1:0] svc_o,
  output logic [NUM_SERVERS-1:0][TALLY_WIDTH-1:0]    eff_tally_o,
  output logic [NUM_SERVERS-1:0]                     mask_o,
  output logic                                       busy_o
);

  localparam int unsigned PW = eca_pkg::SVC_W + TALLY_WIDTH + 1;

  logic [NUM_SERVERS-1:0][eca_pkg::SVC_W-1:0] svc_q, svc_d;
  logic [NUM_SERVERS-1:0][TALLY_WIDTH-1:0]    tally_q, tally_d;
  logic [NUM_SERVERS-1:0][eca_pkg::FIN_W-1:0] fin_q, fin_d;
  logic [NUM_SERVERS-1:0]                     stale_q, stale_d;
  logic [eca_pkg::IN_USE_W-1:0]               in_use_q, in_use_d;

  logic [IW-1:0]             rc_idx;
  logic [PW-1:0]             rc_prod;
  logic [63:0]               rc_prod64;
  logic [eca_pkg::FIN_W-1:0] rc_fin;

  // view of the state as the current job sees it, after an optional batch clear
  always_comb begin
    for (int s = 0; s < NUM_SERVERS; s++) begin
      eff_fin_o[s]   = upd_i.start ? eca_pkg::FIN_W'(svc_q[s]) : fin_q[s];
      eff_tally_o[s] = upd_i.start ? '0 : tally_q[s];
      mask_o[s]      = (s == 0) || (4'(s) < {1'b0, in_use_q});
    end
  end

  assign svc_o  = svc_q;
  assign busy_o = |stale_q;

  // lowest stale server goes through the shared multiplier
  always_comb begin
    rc_idx = '0;
    for (int s = NUM_SERVERS - 1; s >= 0; s--) begin
      if (stale_q[s]) begin
        rc_idx = IW'(s);
      end
    end
  end

  assign rc_prod   = PW'(svc_q[rc_idx]) * (PW'(tally_q[rc_idx]) + PW'(1));
  assign rc_prod64 = 64'(rc_prod);
  assign rc_fin    = (|rc_prod64[63:eca_pkg::FIN_W]) ? '1 : rc_prod64[eca_pkg::FIN_W-1:0];

  // next state: config writes, finish recompute, job assignment
  always_comb begin
    logic [eca_pkg::FIN_W:0] sum;
    svc_d    = svc_q;
    tally_d  = tally_q;
    fin_d    = fin_q;
    stale_d  = stale_q;
    in_use_d = in_use_q;
    sum      = '0;

    // recompute one finish time after a service time change
    if (|stale_q) begin
      fin_d[rc_idx]   = rc_fin;
      stale_d[rc_idx] = 1'b0;
    end

    // job assignment; the chosen server advances unless its tally is full
    if (upd_i.en) begin
      if (upd_i.start) begin
        for (int s = 0; s < NUM_SERVERS; s++) begin
          tally_d[s] = '0;
          fin_d[s]   = eca_pkg::FIN_W'(svc_q[s]);
        end
      end
      if (!(&eff_tally_o[upd_idx_i])) begin
        sum = {1'b0, eff_fin_o[upd_idx_i]} + (eca_pkg::FIN_W + 1)'(svc_q[upd_idx_i]);
        tally_d[upd_idx_i] = eff_tally_o[upd_idx_i] + 1'b1;
        fin_d[upd_idx_i]   = sum[eca_pkg::FIN_W] ? '1 : sum[eca_pkg::FIN_W-1:0];
      end
    end

    // configuration writes
    if (cfg_valid_i) begin
      for (int s = 0; s < NUM_SERVERS; s++) begin
        if ((s < eca_pkg::REG_SERVICE_COUNT) &&
            (cfg_index_i == eca_pkg::CFG_IDX_W'(s))) begin
          svc_d[s]   = cfg_data_i[eca_pkg::SVC_W-1:0];
          stale_d[s] = 1'b1;
        end
      end
      if (cfg_index_i == eca_pkg::REG_SERVERS_IN_USE) begin
        in_use_d = cfg_data_i[eca_pkg::IN_USE_W-1:0];
      end
    end
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < NUM_SERVERS; s++) begin
        svc_q[s]   <= eca_pkg::SVC_RST;
        tally_q[s] <= '0;
        fin_q[s]   <= eca_pkg::FIN_W'(eca_pkg::SVC_RST);
      end
      stale_q  <= '0;
      in_use_q <= eca_pkg::IN_USE_RST;
    end else begin
      svc_q    <= svc_d;
      tally_q  <= tally_d;
      fin_q    <= fin_d;
      stale_q  <= stale_d;
      in_use_q <= in_use_d;
    end
  end

endmodule

### hdl/earliest_finish_counter_assigner_core.sv
// top level: input register, earliest finish selection, result register
// a job accepted into the input register moves to the result register when it advances
// one job per cycle when not stalled; tallies and finish times update in the same cycle
// a service time write stalls jobs while the written server's finish
// time is rebuilt through the one shared multiplier
// reset: service times 1, all servers in use, tallies and makespan zero, both stages empty
module earliest_finish_counter_assigner_core #(
  parameter int unsigned NUM_SERVERS = eca_pkg::NUM_SERVERS_DEF,
  parameter int unsigned TALLY_WIDTH = eca_pkg::TALLY_W_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // [0] start_batch
  input  logic [eca_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // [1:0] chosen_server, [17:2] server_load, [49:18] finish_time,
  // [81:50] makespan, [82] saturated
  output logic [eca_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [eca_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [eca_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  localparam int unsigned IW = (NUM_SERVERS > 1) ? $clog2(NUM_SERVERS) : 1;

  logic in_vld_q, in_vld_d;
  logic in_start_q, in_start_d;
  logic out_vld_q, out_vld_d;
  logic [eca_pkg::OUT_TDATA_W-1:0] out_data_q, out_data_d;
  logic [eca_pkg::FIN_W-1:0] mk_q, mk_d;

  logic                                       advance;
  logic                                       busy;
  eca_pkg::upd_t                              upd;
  logic [NUM_SERVERS-1:0][eca_pkg::FIN_W-1:0] eff_fin;
  logic [NUM_SERVERS-1:0][eca_pkg::SVC_W-1:0] svc;
  logic [NUM_SERVERS-1:0][TALLY_WIDTH-1:0]    eff_tally;
  logic [NUM_SERVERS-1:0]                     mask;
  logic [IW-1:0]                              best_idx;
  logic [eca_pkg::FIN_W-1:0]                  best_fin;
  logic [TALLY_WIDTH-1:0]                     best_tally;
  logic                                       sat;
  logic [TALLY_WIDTH-1:0]                     new_tally;
  logic [31:0]                                new_tally32;
  logic [eca_pkg::FIN_W-1:0]                  mk_base;
  logic [eca_pkg::FIN_W-1:0]                  mk_new;
  logic [eca_pkg::SRV_OUT_W-1:0]              chosen;

  // handshake
  assign advance       = in_vld_q && !busy && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || advance;
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;

  assign upd.en    = advance;
  assign upd.start = in_start_q;

  eca_server_bank #(
    .NUM_SERVERS (NUM_SERVERS),
    .TALLY_WIDTH (TALLY_WIDTH)
  ) u_bank (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .upd_i       (upd),
    .upd_idx_i   (best_idx),
    .eff_fin_o   (eff_fin),
    .svc_o       (svc),
    .eff_tally_o (eff_tally),
    .mask_o      (mask),
    .busy_o      (busy)
  );

  eca_argmin #(
    .NUM_SERVERS (NUM_SERVERS),
    .TALLY_WIDTH (TALLY_WIDTH)
  ) u_argmin (
    .fin_i        (eff_fin),
    .svc_i        (svc),
    .tally_i      (eff_tally),
    .mask_i       (mask),
    .best_idx_o   (best_idx),
    .best_fin_o   (best_fin),
    .best_tally_o (best_tally)
  );

  // result fields
  assign sat         = &best_tally;
  assign new_tally   = sat ? best_tally : best_tally + 1'b1;
  assign new_tally32 = 32'(new_tally);
  assign mk_base     = in_start_q ? '0 : mk_q;
  assign mk_new      = (best_fin > mk_base) ? best_fin : mk_base;
  assign chosen      = eca_pkg::SRV_OUT_W'(best_idx);

  // stage control and result packing
  always_comb begin
    in_vld_d   = in_vld_q;
    in_start_d = in_start_q;
    out_vld_d  = out_vld_q;
    out_data_d = out_data_q;
    mk_d       = mk_q;
    if (advance) begin
      in_vld_d = 1'b0;
    end
    if (s_axis_tvalid && s_axis_tready) begin
      in_vld_d   = 1'b1;
      in_start_d = s_axis_tdata[0];
    end
    if (m_axis_tready) begin
      out_vld_d = 1'b0;
    end
    if (advance) begin
      out_vld_d  = 1'b1;
      mk_d       = mk_new;
      out_data_d = {5'd0, sat, mk_new, best_fin,
                    new_tally32[eca_pkg::LOAD_OUT_W-1:0], chosen};
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      mk_q      <= '0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
      mk_q      <= mk_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    in_start_q <= in_start_d;
    out_data_q <= out_data_d;
  end

endmodule

### hdl/eca_checker.sv
// port-level checks of the assigner and their binding to the top level
module eca_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [eca_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

  // a stalled result transaction holds its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result transaction changed while stalled");

  // the chosen finish time never exceeds the makespan
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[49:18] <= m_axis_tdata[81:50]))
    else $error("finish time above makespan");

  // a saturated tally is a full tally, never zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[82] |-> (m_axis_tdata[17:2] != 16'd0))
    else $error("saturated flag with empty load");

  // no result valid while reset is held
  assert property (@(posedge clk_i)
    !rst_ni |-> !m_axis_tvalid)
    else $error("result valid during reset");

endmodule

bind earliest_finish_counter_assigner_core eca_checker u_eca_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
